/* hw/rtl/spa_pkg.sv */
// Package for the sparse polynomial adder: store sizing and mode codes.
// No dependencies; imported by the core and its checker.
package spa_pkg;

  localparam int MAX_TERMS = 32;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam int EXP_W     = 8;
  localparam int COEF_W    = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int ENTRY_W   = EXP_W + COEF_W;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_MERGE  = 2'd2;

endpackage

/* hw/rtl/sparse_polynomial_adder_core.sv */
// Sparse polynomial adder core: two term stores and an iterative merge sequencer.
// Depends on spa_pkg.
//
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+--------------------------
//  command  | mode, exponent, coefficient                    | start & !busy
//  result   | term_exponent, term_coefficient, last_term,    | result_valid, one cycle,
//           | empty_result, load_error                       | no backpressure
//
// A load (mode A or B) leaves busy low, so loads can go back to back.
// A merge reads the stores (S_FETCH), then compares/adds in the shared adder (S_STEP)
// for each merged exponent, then does a final read, the end check and the flush
// (S_FLUSH); busy stays high for the whole merge.
// Each held result is emitted once the next surviving term is found; the last
// result appears in the cycle busy drops. Reset clears counts and the error flag
// at once; the stores are not cleared and only entries below the counts are read.
module sparse_polynomial_adder_core
  import spa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic [EXP_W-1:0]         exponent,
  input  logic signed [COEF_W-1:0] coefficient,
  output logic                     result_valid,
  output logic [EXP_W-1:0]         term_exponent,
  output logic signed [SUM_W-1:0]  term_coefficient,
  output logic                     last_term,
  output logic                     empty_result,
  output logic                     load_error
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_STEP, S_FLUSH} state_t;

  state_t state;

  logic [ENTRY_W-1:0] store_a [MAX_TERMS];
  logic [ENTRY_W-1:0] store_b [MAX_TERMS];
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;

  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] idx_a;
  logic [CNT_W-1:0] idx_b;
  logic [EXP_W-1:0] last_exp_a;
  logic [EXP_W-1:0] last_exp_b;
  logic             error_seen;

  // held term, emitted once the next survivor (or the end) is known
  logic                    pend_valid;
  logic [EXP_W-1:0]        pend_exp;
  logic signed [SUM_W-1:0] pend_coef;

  logic accept;
  logic load_a_req;
  logic load_b_req;
  logic full_a;
  logic full_b;
  logic order_bad_a;
  logic order_bad_b;
  logic wr_a;
  logic wr_b;
  logic err_a;
  logic err_b;

  logic                     a_ok;
  logic                     b_ok;
  logic [EXP_W-1:0]         ea;
  logic [EXP_W-1:0]         eb;
  logic signed [COEF_W-1:0] ca_sel;
  logic signed [COEF_W-1:0] cb_sel;
  logic                     take_a;
  logic                     take_b;
  logic [EXP_W-1:0]         step_exp;
  logic signed [SUM_W-1:0]  step_sum;

  assign accept     = start && (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign load_a_req = accept && (mode == MODE_LOAD_A) && (coefficient != '0);
  assign load_b_req = accept && (mode == MODE_LOAD_B) && (coefficient != '0);

  assign full_a      = (count_a == CNT_W'(MAX_TERMS));
  assign full_b      = (count_b == CNT_W'(MAX_TERMS));
  assign order_bad_a = (count_a != '0) && (exponent >= last_exp_a);
  assign order_bad_b = (count_b != '0) && (exponent >= last_exp_b);
  assign wr_a        = load_a_req && !full_a && !order_bad_a;
  assign wr_b        = load_b_req && !full_b && !order_bad_b;
  assign err_a       = load_a_req && (full_a || order_bad_a);
  assign err_b       = load_b_req && (full_b || order_bad_b);

  // term stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[count_a[ADDR_W-1:0]] <= {exponent, coefficient};
    end
    if (wr_b) begin
      store_b[count_b[ADDR_W-1:0]] <= {exponent, coefficient};
    end
    rd_a <= store_a[idx_a[ADDR_W-1:0]];
    rd_b <= store_b[idx_b[ADDR_W-1:0]];
  end

  // shared compare and add for one merge step
  always_comb begin
    a_ok     = (idx_a < count_a);
    b_ok     = (idx_b < count_b);
    ea       = rd_a[ENTRY_W-1:COEF_W];
    eb       = rd_b[ENTRY_W-1:COEF_W];
    take_a   = a_ok && (!b_ok || (ea > eb));
    take_b   = b_ok && (!a_ok || (eb > ea));
    ca_sel   = take_b ? '0 : rd_a[COEF_W-1:0];
    cb_sel   = take_a ? '0 : rd_b[COEF_W-1:0];
    step_exp = take_b ? eb : ea;
    step_sum = {ca_sel[COEF_W-1], ca_sel} + {cb_sel[COEF_W-1], cb_sel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count_a      <= '0;
      count_b      <= '0;
      idx_a        <= '0;
      idx_b        <= '0;
      error_seen   <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (wr_a) begin
            count_a    <= count_a + 1'b1;
            last_exp_a <= exponent;
          end
          if (wr_b) begin
            count_b    <= count_b + 1'b1;
            last_exp_b <= exponent;
          end
          if (err_a || err_b) begin
            error_seen <= 1'b1;
          end
          if (accept && (mode == MODE_MERGE)) begin
            idx_a      <= '0;
            idx_b      <= '0;
            pend_valid <= 1'b0;
            state      <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (!a_ok && !b_ok) begin
            state <= S_FLUSH;
          end else begin
            if (!take_b) begin
              idx_a <= idx_a + 1'b1;
            end
            if (!take_a) begin
              idx_b <= idx_b + 1'b1;
            end
            if (step_sum != '0) begin
              if (pend_valid) begin
                result_valid     <= 1'b1;
                term_exponent    <= pend_exp;
                term_coefficient <= pend_coef;
                last_term        <= 1'b0;
                empty_result     <= 1'b0;
                load_error       <= error_seen;
              end
              pend_valid <= 1'b1;
              pend_exp   <= step_exp;
              pend_coef  <= step_sum;
            end
            state <= S_FETCH;
          end
        end
        S_FLUSH: begin
          result_valid     <= 1'b1;
          last_term        <= 1'b1;
          load_error       <= error_seen;
          if (pend_valid) begin
            term_exponent    <= pend_exp;
            term_coefficient <= pend_coef;
            empty_result     <= 1'b0;
          end else begin
            term_exponent    <= '0;
            term_coefficient <= '0;
            empty_result     <= 1'b1;
          end
          pend_valid <= 1'b0;
          count_a    <= '0;
          count_b    <= '0;
          error_seen <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/spa_checker.sv */
// Port-level checker for sparse_polynomial_adder_core, attached by bind.
// Depends on spa_pkg.
module spa_checker
  import spa_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic [1:0]              mode,
  input logic                    result_valid,
  input logic signed [SUM_W-1:0] term_coefficient,
  input logic                    last_term,
  input logic                    empty_result
);

  // a merge transaction always takes the core busy
  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_MERGE)) |=> busy)
    else $error("merge accepted without going busy");

  // only the final result of a merge shows up after busy drops
  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_term) |-> busy)
    else $error("non-final result while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_term) |-> (!busy && !$past(result_valid && last_term)))
    else $error("final result timing wrong");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && empty_result) |-> (last_term && (term_coefficient == '0)))
    else $error("empty result malformed");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !empty_result) |-> (term_coefficient != '0))
    else $error("zero coefficient emitted");

endmodule

bind sparse_polynomial_adder_core spa_checker u_spa_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .mode             (mode),
  .result_valid     (result_valid),
  .term_coefficient (term_coefficient),
  .last_term        (last_term),
  .empty_result     (empty_result)
);
